@@ hdl/servo_pulse_mode_controller_unit_defines.svh @@
// Assertion macros for the servo pulse mode controller.
// Used by the files that check their own logic; needs clk and arst_n in scope.
`ifndef SERVO_PULSE_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define SERVO_PULSE_MODE_CONTROLLER_UNIT_DEFINES_SVH

// Check a property on every rising edge, quiet while reset is applied
`define SPMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define SPMC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/spmc_pkg.sv @@
// Shared types and constants for the servo pulse mode controller.
// No dependencies; imported by spmc_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package spmc_pkg;

	// Operating modes, one-hot
	typedef enum logic [3:0] {
		MODE_POT    = 4'b0001,
		MODE_CENTER = 4'b0010,
		MODE_SWEEP  = 4'b0100,
		MODE_IDLE   = 4'b1000
	} mode_t;

	// Item kinds
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_BUTTON = 1'b1;

	// Compare values
	localparam logic [7:0] CMP_IDLE   = 8'd255;
	localparam logic [7:0] CMP_CENTER = 8'd143;
	localparam logic [7:0] CMP_RESET  = 8'd105;
	localparam logic [7:0] SWEEP_MAX  = 8'd180;
	localparam logic [7:0] SWEEP_MIN  = 8'd105;

	// Tick phase and flash limits
	localparam logic [2:0] PHASE_LAST     = 3'd5;
	localparam logic [4:0] FLASH_FAST_LIM = 5'd1;
	localparam logic [4:0] FLASH_SLOW_LIM = 5'd30;

	// Reciprocals scaled by 2^16: pot*5/17 and pot/25, exact over 0..255
	localparam logic [14:0] RECIP_5_17 = 15'd19280;
	localparam logic [11:0] RECIP_25   = 12'd2622;

	// One result item
	typedef struct packed {
		logic [7:0] compare_value;
		logic       led_on;
		logic       adc_start;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/spmc_ctrl.sv @@
// Mode and pulse state of the servo controller: one item per enabled cycle.
// Depends on spmc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_pulse_mode_controller_unit_defines.svh"

module spmc_ctrl import spmc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic       req_type,
	input  wire logic [7:0] pot_sample,
	output result_t         res
);

	mode_t      mode_q, mode_d;
	logic [2:0] tick_phase_q, tick_phase_d;
	logic [4:0] flash_count_q, flash_count_d;
	logic       sweep_up_q, sweep_up_d;
	logic [7:0] sweep_pos_q, sweep_pos_d;
	logic [7:0] compare_q, compare_d;
	logic       led_q, led_d;
	logic       adc_d;

	logic [22:0] prod17;
	logic [6:0]  pot_scaled;
	logic [19:0] prod25;
	logic [3:0]  step;
	logic [7:0]  pos_up, pos_dn;

	// Constant divisions as reciprocal multiplies
	assign prod17     = 23'(pot_sample) * 23'(RECIP_5_17);
	assign pot_scaled = prod17[22:16];
	assign prod25     = 20'(pot_sample) * 20'(RECIP_25);
	assign step       = prod25[19:16] + 4'd1;
	assign pos_up     = sweep_pos_q + {4'd0, step};
	assign pos_dn     = sweep_pos_q - {4'd0, step};

	// Next state for the item at the input
	always_comb begin
		mode_d        = mode_q;
		tick_phase_d  = tick_phase_q;
		flash_count_d = flash_count_q;
		sweep_up_d    = sweep_up_q;
		sweep_pos_d   = sweep_pos_q;
		compare_d     = compare_q;
		led_d         = led_q;
		adc_d         = 1'b0;
		if (req_type == REQ_TICK) begin
			if (tick_phase_q >= PHASE_LAST) begin
				tick_phase_d = 3'd0;
				case (mode_q)
					MODE_POT: begin
						compare_d = SWEEP_MAX - {1'b0, pot_scaled};
						led_d     = 1'b1;
					end
					MODE_CENTER: begin
						compare_d = CMP_CENTER;
						if (flash_count_q > FLASH_FAST_LIM) begin
							led_d         = ~led_q;
							flash_count_d = 5'd0;
						end else begin
							flash_count_d = flash_count_q + 5'd1;
						end
					end
					MODE_SWEEP: begin
						if (sweep_up_q) begin
							if (pos_up > SWEEP_MAX) begin
								sweep_pos_d = SWEEP_MAX;
								sweep_up_d  = 1'b0;
							end else begin
								sweep_pos_d = pos_up;
							end
						end else begin
							if (pos_dn < SWEEP_MIN) begin
								sweep_pos_d = SWEEP_MIN;
								sweep_up_d  = 1'b1;
							end else begin
								sweep_pos_d = pos_dn;
							end
						end
						compare_d = sweep_pos_d;
						if (flash_count_q > FLASH_SLOW_LIM) begin
							led_d         = ~led_q;
							flash_count_d = 5'd0;
						end else begin
							flash_count_d = flash_count_q + 5'd1;
						end
					end
					default: begin
					end
				endcase
			end else begin
				// Hold the output low and start a conversion
				tick_phase_d = tick_phase_q + 3'd1;
				compare_d    = CMP_IDLE;
				adc_d        = 1'b1;
			end
		end else begin
			// Advance the mode on a button press
			case (mode_q)
				MODE_POT: mode_d = MODE_CENTER;
				MODE_CENTER: begin
					mode_d    = MODE_SWEEP;
					compare_d = CMP_CENTER;
				end
				default: mode_d = MODE_POT;
			endcase
		end
	end

	assign res.compare_value = compare_d;
	assign res.led_on        = led_d;
	assign res.adc_start     = adc_d;

	// Commit state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			tick_phase_q  <= 3'd0;
			flash_count_q <= 5'd0;
			sweep_up_q    <= 1'b1;
			sweep_pos_q   <= CMP_CENTER;
			compare_q     <= CMP_RESET;
			led_q         <= 1'b0;
		end else if (step_en) begin
			mode_q        <= mode_d;
			tick_phase_q  <= tick_phase_d;
			flash_count_q <= flash_count_d;
			sweep_up_q    <= sweep_up_d;
			sweep_pos_q   <= sweep_pos_d;
			compare_q     <= compare_d;
			led_q         <= led_d;
		end
	end

	`SPMC_ASSERT(a_phase_range, tick_phase_q <= PHASE_LAST, "tick phase out of range")
	`SPMC_ASSERT(a_adc_idle, step_en && res.adc_start |-> res.compare_value == CMP_IDLE, "adc start without idle compare")
	`SPMC_ASSERT(a_sweep_range, sweep_pos_q >= SWEEP_MIN && sweep_pos_q <= SWEEP_MAX, "sweep position out of range")

endmodule

`default_nettype wire

@@ hdl/servo_pulse_mode_controller_unit.sv @@
// Servo pulse mode controller: input register, one pass of mode logic, two-entry result buffer.
// Each accepted item is held in the input register, then written to the buffer as its result.
// Throughput: one item per cycle while the buffer has or frees a slot; single-pass spmc_ctrl.
// The two-entry result buffer lets items keep flowing while results stall, until it is full.
// Reset (arst_n low, asynchronous): idle mode, phase 0, compare 105, LED off, buffers empty.
// Depends on spmc_pkg, spmc_ctrl and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_pulse_mode_controller_unit_defines.svh"

module servo_pulse_mode_controller_unit import spmc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic       req_type,
	input  wire logic [7:0] pot_sample,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [7:0]      compare_value,
	output logic            led_on,
	output logic            adc_start
);

	logic       valid_s1;
	logic       req_s1;
	logic [7:0] pot_s1;
	logic       s1_move;
	logic       pop;

	result_t    res;
	result_t    buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// Handshake: stage one moves when the buffer has or frees a slot
	assign pop       = res_valid && res_ready;
	assign s1_move   = valid_s1 && ((count_q != 2'd2) || pop);
	assign req_ready = !valid_s1 || s1_move;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_type;
			pot_s1 <= pot_sample;
		end
	end

	spmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (s1_move),
		.req_type   (req_s1),
		.pot_sample (pot_s1),
		.res        (res)
	);

	// Result buffer pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (s1_move) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({s1_move, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	assign res_valid     = count_q != 2'd0;
	assign compare_value = buf_q[rd_ptr_q].compare_value;
	assign led_on        = buf_q[rd_ptr_q].led_on;
	assign adc_start     = buf_q[rd_ptr_q].adc_start;

	`SPMC_ASSERT(a_count_range, count_q != 2'd3, "result buffer overfilled")
	`SPMC_ASSERT(a_s1_hold,
		valid_s1 && !s1_move |=> valid_s1 && $stable(req_s1) && $stable(pot_s1),
		"stalled item lost")
	`SPMC_ASSERT(a_ptr_fill, (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q),
		"buffer pointers disagree with fill")

endmodule

`default_nettype wire
